// ===== rtl/tce_pkg.sv =====
// ----------------------------------------------------------------------------
// Teaching CPU execute stage package
// Shared widths, opcodes and the structs that pass between the stage modules.
// ----------------------------------------------------------------------------
package tce_pkg;

    localparam int REG_COUNT  = 16;
    localparam int REG_IDX_W  = $clog2(REG_COUNT);
    localparam int MEM_WORDS  = 2048;
    localparam int MEM_ADDR_W = $clog2(MEM_WORDS);
    localparam int IO_REGS    = 4;
    localparam int IO_IDX_W   = $clog2(IO_REGS);
    localparam int DATA_W     = 32;
    localparam int PC_W       = 16;
    localparam int IMM_W      = 16;
    localparam int OP_W       = 4;
    localparam int BYTE_W     = 8;
    localparam int SHAMT_W    = 5;

    // Register file read ports: rs, rt and rd.
    localparam int RD_PORTS = 3;
    localparam int PORT_A   = 0;
    localparam int PORT_B   = 1;
    localparam int PORT_C   = 2;

    localparam logic [REG_IDX_W-1:0] IMM_REG   = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] LINK_REG  = REG_IDX_W'(15);
    localparam logic [REG_IDX_W-1:0] IO_RD_SEL = REG_IDX_W'(0);
    localparam logic [DATA_W-1:0]    LED_PORT    = DATA_W'(1);
    localparam logic [DATA_W-1:0]    LOCKED_PORT = DATA_W'(2);

    typedef enum logic [OP_W-1:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_AND  = 4'd2,
        OP_OR   = 4'd3,
        OP_SLL  = 4'd4,
        OP_SRA  = 4'd5,
        OP_IO   = 4'd6,
        OP_BEQ  = 4'd7,
        OP_BGT  = 4'd8,
        OP_BLE  = 4'd9,
        OP_BNE  = 4'd10,
        OP_JAL  = 4'd11,
        OP_LW   = 4'd12,
        OP_SW   = 4'd13,
        OP_LHI  = 4'd14,
        OP_HALT = 4'd15
    } op_t;

    typedef struct packed {
        op_t                   op;
        logic                  uses_imm;
        logic [REG_IDX_W-1:0]  rd;
        logic [REG_IDX_W-1:0]  rs;
        logic [REG_IDX_W-1:0]  rt;
        logic [IMM_W-1:0]      imm;
        logic [PC_W-1:0]       pc;
    } instr_t;

    typedef struct packed {
        logic                  en;
        logic [REG_IDX_W-1:0]  idx;
        logic [DATA_W-1:0]     data;
    } reg_wr_t;

    typedef struct packed {
        logic                  jump_taken;
        logic [PC_W-1:0]       jump_target;
        logic                  halted;
        logic                  led_write;
        logic [BYTE_W-1:0]     led_value;
        logic                  imm_used_out;
    } result_t;

    typedef struct packed {
        reg_wr_t               reg_wr;
        logic                  is_load;
        logic                  mem_we;
        logic [MEM_ADDR_W-1:0] mem_addr;
        logic [DATA_W-1:0]     mem_data;
        logic                  io_we;
        logic [IO_IDX_W-1:0]   io_idx;
        logic [BYTE_W-1:0]     io_data;
        result_t               res;
    } exec_t;

endpackage

// ===== rtl/tce_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data; a read of the
// address being written returns the new data.
// ----------------------------------------------------------------------------
module tce_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (we && (waddr == raddr))
        begin
            rdata_reg <= wdata;
        end
        else
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/tce_regfile.sv =====
// ----------------------------------------------------------------------------
// Register file
// Three read copies of the 16 x 32 register file, per-entry valid bits for
// the zero reset value, and a bypass of the write that is in flight.
// ----------------------------------------------------------------------------
module tce_regfile (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [tce_pkg::REG_IDX_W-1:0]   rd_addr [tce_pkg::RD_PORTS],
    input  tce_pkg::reg_wr_t                wr,
    output logic [tce_pkg::DATA_W-1:0]      rd_data [tce_pkg::RD_PORTS]
);
    import tce_pkg::*;

    logic [REG_COUNT-1:0] valid_reg;
    logic [REG_IDX_W-1:0] addr_reg  [RD_PORTS];
    logic [DATA_W-1:0]    ram_rdata [RD_PORTS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.en)
        begin
            valid_reg[wr.idx] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int p = 0; p < RD_PORTS; p++)
        begin
            addr_reg[p] <= rd_addr[p];
        end
    end

    for (genvar g = 0; g < RD_PORTS; g++)
    begin : g_copy
        tce_ram #(
            .WIDTH(DATA_W),
            .DEPTH(REG_COUNT)
        ) u_ram (
            .clk  (clk),
            .we   (wr.en),
            .waddr(wr.idx),
            .wdata(wr.data),
            .raddr(rd_addr[g]),
            .rdata(ram_rdata[g])
        );
    end

    // The write port carries the previous instruction's result, which the
    // registered read data cannot have seen yet.
    always_comb
    begin
        for (int p = 0; p < RD_PORTS; p++)
        begin
            if (wr.en && (wr.idx == addr_reg[p]))
            begin
                rd_data[p] = wr.data;
            end
            else if (valid_reg[addr_reg[p]])
            begin
                rd_data[p] = ram_rdata[p];
            end
            else
            begin
                rd_data[p] = '0;
            end
        end
    end

endmodule

// ===== rtl/tce_exec.sv =====
// ----------------------------------------------------------------------------
// Execute logic
// Combinational datapath for one instruction: ALU, branch compare, jal link,
// memory address and IO decode.
// ----------------------------------------------------------------------------
module tce_exec (
    input  tce_pkg::instr_t                 instr,
    input  logic [tce_pkg::DATA_W-1:0]      op_a,
    input  logic [tce_pkg::DATA_W-1:0]      op_b,
    input  logic [tce_pkg::DATA_W-1:0]      op_c,
    input  logic [tce_pkg::BYTE_W-1:0]      io_rdata,
    output tce_pkg::exec_t                  ex
);
    import tce_pkg::*;

    logic [DATA_W-1:0] imm_ext;
    logic [DATA_W-1:0] sel_a;
    logic [DATA_W-1:0] sel_b;
    logic [DATA_W-1:0] sum_sel;
    logic [DATA_W-1:0] link;
    logic              io_in_range;
    logic              cond;

    assign imm_ext     = {{(DATA_W-IMM_W){instr.imm[IMM_W-1]}}, instr.imm};
    assign sel_a       = (instr.rs == IMM_REG) ? imm_ext : op_a;
    assign sel_b       = (instr.rt == IMM_REG) ? imm_ext : op_b;
    assign sum_sel     = sel_a + sel_b;
    assign link        = {{(DATA_W-PC_W){1'b0}}, instr.pc}
                       + (instr.uses_imm ? DATA_W'(2) : DATA_W'(1));
    assign io_in_range = (op_a < DATA_W'(IO_REGS));

    always_comb
    begin
        case (instr.op)
            OP_BEQ:  cond = (op_a == op_b);
            OP_BGT:  cond = ($signed(op_a) > $signed(op_b));
            OP_BLE:  cond = ($signed(op_a) <= $signed(op_b));
            OP_BNE:  cond = (op_a != op_b);
            default: cond = 1'b0;
        endcase
    end

    always_comb
    begin
        ex                  = '0;
        ex.reg_wr.idx       = instr.rd;
        ex.mem_addr         = sum_sel[MEM_ADDR_W-1:0];
        ex.mem_data         = op_c;
        ex.io_idx           = op_a[IO_IDX_W-1:0];
        ex.io_data          = op_c[BYTE_W-1:0];
        ex.res.imm_used_out = instr.uses_imm;

        case (instr.op)
            OP_ADD:
            begin
                ex.reg_wr.en   = 1'b1;
                ex.reg_wr.data = instr.uses_imm ? sum_sel : op_a + op_b;
            end
            OP_SUB:
            begin
                ex.reg_wr.en   = 1'b1;
                ex.reg_wr.data = instr.uses_imm ? sel_a - sel_b : op_a - op_b;
            end
            OP_AND:
            begin
                ex.reg_wr.en   = 1'b1;
                ex.reg_wr.data = op_a & op_b;
            end
            OP_OR:
            begin
                ex.reg_wr.en   = 1'b1;
                ex.reg_wr.data = op_a | op_b;
            end
            OP_SLL:
            begin
                ex.reg_wr.en   = 1'b1;
                ex.reg_wr.data = op_a << op_b[SHAMT_W-1:0];
            end
            OP_SRA:
            begin
                ex.reg_wr.en   = 1'b1;
                ex.reg_wr.data = $unsigned($signed(op_a) >>> op_b[SHAMT_W-1:0]);
            end
            OP_IO:
            begin
                ex.res.imm_used_out = 1'b0;
                if (instr.rt == IO_RD_SEL)
                begin
                    ex.reg_wr.en   = 1'b1;
                    ex.reg_wr.data = io_in_range
                                   ? {{(DATA_W-BYTE_W){1'b0}}, io_rdata} : '0;
                end
                else if (op_a == LOCKED_PORT)
                begin
                    // A write to the locked port writes no IO register and keeps the immediate flag.
                    ex.res.imm_used_out = instr.uses_imm;
                end
                else
                begin
                    ex.io_we = io_in_range;
                    if (op_a == LED_PORT)
                    begin
                        ex.res.led_write = 1'b1;
                        ex.res.led_value = op_c[BYTE_W-1:0];
                    end
                end
            end
            OP_BEQ, OP_BGT, OP_BLE, OP_BNE:
            begin
                if (cond)
                begin
                    ex.res.jump_taken  = 1'b1;
                    ex.res.jump_target = op_c[PC_W-1:0];
                end
            end
            OP_JAL:
            begin
                ex.reg_wr.en       = 1'b1;
                ex.reg_wr.idx      = LINK_REG;
                ex.reg_wr.data     = link;
                ex.res.jump_taken  = 1'b1;
                // The link is written before the target is read, so rd = 15
                // jumps through the new link value.
                if (instr.rd == IMM_REG)
                begin
                    ex.res.jump_target = instr.imm;
                end
                else if (instr.rd == LINK_REG)
                begin
                    ex.res.jump_target = link[PC_W-1:0];
                end
                else
                begin
                    ex.res.jump_target = op_c[PC_W-1:0];
                end
            end
            OP_LW:
            begin
                ex.reg_wr.en = 1'b1;
                ex.is_load   = 1'b1;
            end
            OP_SW:
            begin
                ex.mem_we = 1'b1;
            end
            OP_LHI:
            begin
                ex.reg_wr.en   = 1'b1;
                ex.reg_wr.data = {op_a[DATA_W-PC_W-1:0], op_c[PC_W-1:0]};
            end
            default:
            begin
                ex.res.halted = 1'b1;
            end
        endcase
    end

endmodule

// ===== rtl/teaching_cpu_execute_stage_top.sv =====
// ----------------------------------------------------------------------------
// Teaching CPU execute stage
// Executes one decoded instruction per transfer against the register file,
// the data memory and the IO registers, and reports jumps, halt and LEDs.
// ----------------------------------------------------------------------------
// Usage:
// - Input channel (in_valid / in_stall) carries one decoded instruction per
//   transfer; output channel (out_valid / out_stall) carries one result.
// - An instruction's operands are read from the register file in the cycle after
//   its transfer, while it sits in the execute register; it is executed there and
//   its result is registered into the output register, which raises out_valid.
// - Throughput is one instruction per cycle while out_stall is low. Register and
//   load results are held in the write-back register and forwarded, so
//   dependent instructions follow back to back without bubbles.
// - When out_stall holds a finished result, one more instruction is taken
//   into the execute register; after that in_stall goes high until the
//   result is taken.
// - After reset the data memory is cleared one word per cycle, all MEM_WORDS
//   (2048) words; in_stall stays high during that pass. Registers and IO
//   registers read as zero right after reset.
// ----------------------------------------------------------------------------
module teaching_cpu_execute_stage_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [tce_pkg::OP_W-1:0]        operation,
    input  logic                            uses_imm,
    input  logic [tce_pkg::REG_IDX_W-1:0]   dest_index,
    input  logic [tce_pkg::REG_IDX_W-1:0]   src_a_index,
    input  logic [tce_pkg::REG_IDX_W-1:0]   src_b_index,
    input  logic signed [tce_pkg::IMM_W-1:0] immediate,
    input  logic [tce_pkg::PC_W-1:0]        current_pc,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            jump_taken,
    output logic [tce_pkg::PC_W-1:0]        jump_target,
    output logic                            halted,
    output logic                            led_write,
    output logic [tce_pkg::BYTE_W-1:0]      led_value,
    output logic                            imm_used_out
);
    import tce_pkg::*;

    instr_t                in_instr;
    instr_t                e_instr_reg;
    logic                  e_valid_reg;
    logic                  out_valid_reg;
    result_t               out_res_reg;
    reg_wr_t               w_reg;
    logic                  w_load_reg;
    reg_wr_t               wr_port;
    logic [MEM_ADDR_W-1:0] clr_cnt_reg;
    logic                  clr_done_reg;
    logic [BYTE_W-1:0]     io_reg [IO_REGS];

    logic                  clearing;
    logic                  out_free;
    logic                  e_adv;
    logic                  in_accept;
    logic [REG_IDX_W-1:0]  rf_addr [RD_PORTS];
    logic [DATA_W-1:0]     rf_data [RD_PORTS];
    logic [DATA_W-1:0]     dmem_rdata;
    logic                  dmem_we;
    logic [MEM_ADDR_W-1:0] dmem_waddr;
    logic [DATA_W-1:0]     dmem_wdata;
    exec_t                 ex;

    assign in_instr.op       = op_t'(operation);
    assign in_instr.uses_imm = uses_imm;
    assign in_instr.rd       = dest_index;
    assign in_instr.rs       = src_a_index;
    assign in_instr.rt       = src_b_index;
    assign in_instr.imm      = $unsigned(immediate);
    assign in_instr.pc       = current_pc;

    assign clearing  = !clr_done_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign e_adv     = e_valid_reg && out_free;
    assign in_stall  = clearing || (e_valid_reg && !out_free);
    assign in_accept = in_valid && !in_stall;

    // ---------------------------------------------------------------- control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            w_reg         <= '0;
            clr_cnt_reg   <= '0;
            clr_done_reg  <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                e_valid_reg <= 1'b1;
            end
            else if (e_adv)
            begin
                e_valid_reg <= 1'b0;
            end

            if (e_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_free)
            begin
                out_valid_reg <= 1'b0;
            end

            w_reg.en <= e_adv && ex.reg_wr.en;
            if (e_adv)
            begin
                w_reg.idx  <= ex.reg_wr.idx;
                w_reg.data <= ex.reg_wr.data;
            end

            if (clearing)
            begin
                clr_cnt_reg <= clr_cnt_reg + MEM_ADDR_W'(1);
                if (clr_cnt_reg == MEM_ADDR_W'(MEM_WORDS - 1))
                begin
                    clr_done_reg <= 1'b1;
                end
            end
        end
    end

    // ---------------------------------------------------------------- payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            e_instr_reg <= in_instr;
        end
        if (e_adv)
        begin
            out_res_reg <= ex.res;
            w_load_reg  <= ex.is_load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < IO_REGS; i++)
            begin
                io_reg[i] <= '0;
            end
        end
        else if (e_adv && ex.io_we)
        begin
            io_reg[ex.io_idx] <= ex.io_data;
        end
    end

    // ---------------------------------------------------------- register file
    // While an instruction waits in the execute register its operands are
    // read again every cycle, so writes that land meanwhile are picked up.
    assign rf_addr[PORT_A] = in_accept ? src_a_index : e_instr_reg.rs;
    assign rf_addr[PORT_B] = in_accept ? src_b_index : e_instr_reg.rt;
    assign rf_addr[PORT_C] = in_accept ? dest_index  : e_instr_reg.rd;

    assign wr_port.en   = w_reg.en;
    assign wr_port.idx  = w_reg.idx;
    assign wr_port.data = w_load_reg ? dmem_rdata : w_reg.data;

    tce_regfile u_regfile (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_addr(rf_addr),
        .wr     (wr_port),
        .rd_data(rf_data)
    );

    // ---------------------------------------------------------------- execute
    tce_exec u_exec (
        .instr   (e_instr_reg),
        .op_a    (rf_data[PORT_A]),
        .op_b    (rf_data[PORT_B]),
        .op_c    (rf_data[PORT_C]),
        .io_rdata(io_reg[rf_data[PORT_A][IO_IDX_W-1:0]]),
        .ex      (ex)
    );

    // ------------------------------------------------------------ data memory
    assign dmem_we    = clearing || (e_adv && ex.mem_we);
    assign dmem_waddr = clearing ? clr_cnt_reg : ex.mem_addr;
    assign dmem_wdata = clearing ? '0 : ex.mem_data;

    tce_ram #(
        .WIDTH(DATA_W),
        .DEPTH(MEM_WORDS)
    ) u_dmem (
        .clk  (clk),
        .we   (dmem_we),
        .waddr(dmem_waddr),
        .wdata(dmem_wdata),
        .raddr(ex.mem_addr),
        .rdata(dmem_rdata)
    );

    // ----------------------------------------------------------------- output
    assign out_valid    = out_valid_reg;
    assign jump_taken   = out_res_reg.jump_taken;
    assign jump_target  = out_res_reg.jump_target;
    assign halted       = out_res_reg.halted;
    assign led_write    = out_res_reg.led_write;
    assign led_value    = out_res_reg.led_value;
    assign imm_used_out = out_res_reg.imm_used_out;

    // ------------------------------------------------------------- assertions
    a_wb_follows_adv: assert property (@(posedge clk) disable iff (!rst_n)
        w_reg.en |-> $past(e_adv))
        else $error("register write-back without a preceding execute transfer");

    a_exec_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (e_valid_reg && !out_free) |=> (e_valid_reg && $stable(e_instr_reg)))
        else $error("stalled instruction left the execute register");

    a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> (!e_valid_reg && !out_valid_reg && !w_reg.en))
        else $error("pipeline active during the memory clearing pass");

    a_led_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && led_write) |-> (!jump_taken && !halted && !imm_used_out))
        else $error("LED write combined with another instruction effect");

    a_one_store: assert property (@(posedge clk) disable iff (!rst_n)
        e_adv |-> !(ex.reg_wr.en && ex.mem_we))
        else $error("instruction writes both register file and data memory");

endmodule

// ===== test/teaching_cpu_execute_stage_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Teaching CPU execute stage testbench
// Sends decoded instructions over the valid/stall input channel, predicts
// each result from a private copy of the register file, data memory and IO
// registers, and checks every result transfer in order. Directed cases come
// first, then a random instruction stream with random gaps and stalls.
// ----------------------------------------------------------------------------
module teaching_cpu_execute_stage_top_tb;

    import tce_pkg::*;

    localparam int TOTAL_ITEMS    = 950;
    localparam int WATCHDOG_LIMIT = 6000;
    localparam int IDLE_PERCENT   = 18;

    logic    clk = 1'b0;
    logic    rst_n;
    logic    in_valid;
    logic    in_stall;
    logic    out_valid;
    logic    out_stall = 1'b0;
    instr_t  drive_item;
    logic    jump_taken;
    logic [PC_W-1:0]   jump_target;
    logic    halted;
    logic    led_write;
    logic [BYTE_W-1:0] led_value;
    logic    imm_used_out;

    // Private architectural state used for prediction.
    logic [DATA_W-1:0] gpr_state [REG_COUNT];
    logic [DATA_W-1:0] dmem_state [MEM_WORDS];
    logic [BYTE_W-1:0] io_state [IO_REGS];

    result_t pending_results [$];
    int      items_sent;
    int      results_checked;
    int      mismatches;
    int      idle_cycles;
    bit      calm;

    teaching_cpu_execute_stage_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (drive_item.op),
        .uses_imm     (drive_item.uses_imm),
        .dest_index   (drive_item.rd),
        .src_a_index  (drive_item.rs),
        .src_b_index  (drive_item.rt),
        .immediate    (drive_item.imm),
        .current_pc   (drive_item.pc),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .jump_taken   (jump_taken),
        .jump_target  (jump_target),
        .halted       (halted),
        .led_write    (led_write),
        .led_value    (led_value),
        .imm_used_out (imm_used_out)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Executes one instruction on the private state and returns its result.
    function automatic result_t execute_instr(instr_t ins);
        result_t           r;
        logic [DATA_W-1:0] imm32;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] sel_a;
        logic [DATA_W-1:0] sel_b;
        logic [DATA_W-1:0] sum;
        logic signed [DATA_W-1:0] a_signed;
        logic [MEM_ADDR_W-1:0] addr;
        logic              cond;
        r = '0;
        r.imm_used_out = ins.uses_imm;
        imm32 = {{(DATA_W - IMM_W){ins.imm[IMM_W-1]}}, ins.imm};
        a = gpr_state[ins.rs];
        b = gpr_state[ins.rt];
        a_signed = a;
        sel_a = (ins.rs == IMM_REG) ? imm32 : a;
        sel_b = (ins.rt == IMM_REG) ? imm32 : b;
        sum = sel_a + sel_b;
        addr = sum[MEM_ADDR_W-1:0];
        cond = 1'b0;
        case (ins.op)
            OP_ADD:  gpr_state[ins.rd] = ins.uses_imm ? sel_a + sel_b : a + b;
            OP_SUB:  gpr_state[ins.rd] = ins.uses_imm ? sel_a - sel_b : a - b;
            OP_AND:  gpr_state[ins.rd] = a & b;
            OP_OR:   gpr_state[ins.rd] = a | b;
            OP_SLL:  gpr_state[ins.rd] = a << b[SHAMT_W-1:0];
            OP_SRA:  gpr_state[ins.rd] = a_signed >>> b[SHAMT_W-1:0];
            OP_IO:
            begin
                if (ins.rt == IO_RD_SEL)
                begin
                    gpr_state[ins.rd] = (a < IO_REGS) ? DATA_W'(io_state[a[IO_IDX_W-1:0]]) : '0;
                    r.imm_used_out = 1'b0;
                end
                else if (a != LOCKED_PORT)
                begin
                    if (a < IO_REGS)
                        io_state[a[IO_IDX_W-1:0]] = gpr_state[ins.rd][BYTE_W-1:0];
                    if (a == LED_PORT)
                    begin
                        r.led_write = 1'b1;
                        r.led_value = gpr_state[ins.rd][BYTE_W-1:0];
                    end
                    r.imm_used_out = 1'b0;
                end
            end
            OP_BEQ, OP_BGT, OP_BLE, OP_BNE:
            begin
                case (ins.op)
                    OP_BEQ:  cond = (a == b);
                    OP_BGT:  cond = ($signed(a) > $signed(b));
                    OP_BLE:  cond = ($signed(a) <= $signed(b));
                    default: cond = (a != b);
                endcase
                if (cond)
                begin
                    r.jump_taken  = 1'b1;
                    r.jump_target = gpr_state[ins.rd][PC_W-1:0];
                end
            end
            OP_JAL:
            begin
                // The link is written before the target is read, so rd of 15
                // jumps to the new link value.
                gpr_state[LINK_REG] = DATA_W'(ins.pc) + (ins.uses_imm ? 32'd2 : 32'd1);
                r.jump_taken  = 1'b1;
                r.jump_target = (ins.rd == IMM_REG) ? ins.imm
                                                    : gpr_state[ins.rd][PC_W-1:0];
            end
            OP_LW:   gpr_state[ins.rd] = dmem_state[addr];
            OP_SW:   dmem_state[addr] = gpr_state[ins.rd];
            OP_LHI:  gpr_state[ins.rd] = {16'h0000, gpr_state[ins.rd][15:0]}
                                         + (gpr_state[ins.rs] << 16);
            default: r.halted = 1'b1;
        endcase
        return r;
    endfunction

    function automatic instr_t make_instr(op_t op, logic imm_flag, int rd, int rs, int rt,
                                          logic [IMM_W-1:0] imm, logic [PC_W-1:0] pc);
        instr_t ins;
        ins.op       = op;
        ins.uses_imm = imm_flag;
        ins.rd       = REG_IDX_W'(rd);
        ins.rs       = REG_IDX_W'(rs);
        ins.rt       = REG_IDX_W'(rt);
        ins.imm      = imm;
        ins.pc       = pc;
        return ins;
    endfunction

    function automatic instr_t random_instr();
        return make_instr(op_t'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                          $urandom_range(0, 15), $urandom_range(0, 15),
                          $urandom_range(0, 15), IMM_W'($urandom), PC_W'($urandom));
    endfunction

    // Called and returns at a falling edge. Valid is held across back-to-back
    // items and only dropped for a random gap.
    task automatic send_instr(instr_t ins);
        int gap;
        if (!calm && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            gap = $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        drive_item <= ins;
        in_valid   <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        pending_results.push_back(execute_instr(ins));
        items_sent++;
        @(negedge clk);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("Result %0d: %s expected 0x%0h, got 0x%0h",
                         results_checked, field, want, got);
        end
    endtask

    task automatic test_alu_ops();
        send_instr(make_instr(OP_ADD, 1'b1, 2, 0, 1, 16'h7FFF, 16'h0000));
        send_instr(make_instr(OP_ADD, 1'b1, 3, 1, 1, 16'h8000, 16'h0001));
        send_instr(make_instr(OP_SUB, 1'b1, 4, 2, 1, 16'hFFFF, 16'h0002));
        send_instr(make_instr(OP_SUB, 1'b0, 5, 3, 2, 16'h0000, 16'h0003));
        // Without the immediate flag, index 1 reads register 1.
        send_instr(make_instr(OP_ADD, 1'b0, 6, 1, 4, 16'h1234, 16'h0004));
        send_instr(make_instr(OP_AND, 1'b0, 7, 5, 4, 16'h0000, 16'h0005));
        send_instr(make_instr(OP_OR, 1'b1, 8, 3, 2, 16'h0000, 16'h0006));
        send_instr(make_instr(OP_ADD, 1'b1, 10, 0, 1, 16'd31, 16'h0007));
        send_instr(make_instr(OP_SLL, 1'b0, 9, 2, 10, 16'h0000, 16'h0008));
        send_instr(make_instr(OP_SRA, 1'b0, 11, 3, 10, 16'h0000, 16'h0009));
        send_instr(make_instr(OP_LHI, 1'b0, 2, 4, 0, 16'h0000, 16'h000A));
    endtask

    task automatic test_io_ports();
        send_instr(make_instr(OP_ADD, 1'b1, 12, 0, 1, 16'd1, 16'h0010));
        send_instr(make_instr(OP_ADD, 1'b1, 13, 0, 1, 16'd2, 16'h0011));
        send_instr(make_instr(OP_ADD, 1'b1, 14, 0, 1, 16'd3, 16'h0012));
        send_instr(make_instr(OP_IO, 1'b1, 11, 12, 3, 16'h0000, 16'h0013));
        // The locked port ignores the write and keeps the immediate flag.
        send_instr(make_instr(OP_IO, 1'b1, 2, 13, 15, 16'h0000, 16'h0014));
        send_instr(make_instr(OP_IO, 1'b1, 11, 14, 1, 16'h0000, 16'h0015));
        send_instr(make_instr(OP_IO, 1'b0, 2, 10, 7, 16'h0000, 16'h0016));
        send_instr(make_instr(OP_IO, 1'b1, 5, 12, 0, 16'h0000, 16'h0017));
        send_instr(make_instr(OP_IO, 1'b0, 6, 10, 0, 16'h0000, 16'h0018));
    endtask

    task automatic test_control_flow();
        send_instr(make_instr(OP_BEQ, 1'b0, 2, 0, 0, 16'h0000, 16'h0000));
        send_instr(make_instr(OP_BGT, 1'b0, 2, 3, 0, 16'h0000, 16'h0020));
        send_instr(make_instr(OP_BLE, 1'b0, 12, 3, 0, 16'h0000, 16'h0021));
        send_instr(make_instr(OP_BNE, 1'b0, 2, 0, 0, 16'h0000, 16'h0022));
        send_instr(make_instr(OP_BGT, 1'b0, 13, 0, 11, 16'h0000, 16'h0023));
        send_instr(make_instr(OP_JAL, 1'b1, 1, 0, 0, 16'h8000, 16'hFFFF));
        send_instr(make_instr(OP_JAL, 1'b0, 15, 0, 0, 16'h0000, 16'h0100));
    endtask

    task automatic test_memory_access();
        // An address that wraps below zero lands at the top of the memory.
        send_instr(make_instr(OP_SW, 1'b1, 11, 1, 1, 16'hFFFF, 16'h0030));
        send_instr(make_instr(OP_LW, 1'b0, 7, 1, 1, 16'hFFFF, 16'h0031));
        send_instr(make_instr(OP_SW, 1'b0, 2, 12, 0, 16'h0000, 16'h0032));
        send_instr(make_instr(OP_LW, 1'b1, 8, 0, 12, 16'h0000, 16'h0033));
        send_instr(make_instr(OP_HALT, 1'b1, 0, 0, 0, 16'h7FFF, 16'hFFFF));
    endtask

    task automatic test_random_program();
        int     pick;
        int     k;
        instr_t ins;
        bit     paused;
        paused = 1'b0;
        while (items_sent < TOTAL_ITEMS)
        begin
            calm = (items_sent >= 400 && items_sent < 550);
            if (!paused && items_sent >= 650)
            begin
                wait_for_results();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 20)
            begin
                // Load a small IO index into a register, then access that port.
                k = $urandom_range(2, 15);
                send_instr(make_instr(OP_SUB, 1'b1, k, 1, 1, IMM_W'($urandom),
                                      PC_W'($urandom)));
                send_instr(make_instr(OP_ADD, 1'b1, k, k, 1, IMM_W'($urandom_range(0, 4)),
                                      PC_W'($urandom)));
                send_instr(make_instr(OP_IO, 1'($urandom_range(0, 1)), $urandom_range(0, 15),
                                      k, ($urandom_range(0, 2) == 0) ? 0
                                                                     : $urandom_range(1, 15),
                                      IMM_W'($urandom), PC_W'($urandom)));
            end
            else if (pick < 40)
            begin
                // Store followed by a load from the same address.
                ins = random_instr();
                ins.op = OP_SW;
                send_instr(ins);
                ins.op = OP_LW;
                ins.rd = REG_IDX_W'($urandom_range(0, 15));
                ins.pc = PC_W'($urandom);
                send_instr(ins);
            end
            else
                send_instr(random_instr());
        end
        calm = 1'b0;
    endtask

    always @(negedge clk)
        out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PERCENT);

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Result transfer with no instruction outstanding");
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("jump_taken", 32'(want.jump_taken), 32'(jump_taken));
                check_field("jump_target", 32'(want.jump_target), 32'(jump_target));
                check_field("halted", 32'(want.halted), 32'(halted));
                check_field("led_write", 32'(want.led_write), 32'(led_write));
                check_field("led_value", 32'(want.led_value), 32'(led_value));
                check_field("imm_used_out", 32'(want.imm_used_out), 32'(imm_used_out));
                results_checked++;
            end
        end
    end

    // The count restarts on any transfer; the memory clearing pass after
    // reset is the longest legal stretch without one.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("No transfer for %0d cycles, %0d results outstanding",
                         idle_cycles, pending_results.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        drive_item <= '0;
        items_sent      = 0;
        results_checked = 0;
        mismatches      = 0;
        idle_cycles     = 0;
        calm            = 1'b0;
        for (int i = 0; i < REG_COUNT; i++)
            gpr_state[i] = '0;
        for (int i = 0; i < MEM_WORDS; i++)
            dmem_state[i] = '0;
        for (int i = 0; i < IO_REGS; i++)
            io_state[i] = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_alu_ops();
        test_io_ports();
        test_control_flow();
        test_memory_access();
        wait_for_results();
        test_random_program();
        wait_for_results();
        repeat (8) @(posedge clk);

        $display("Ran %0d instructions: directed ALU, IO, branch, jump and memory cases,",
                 items_sent);
        $display("then a random program; %0d results checked, %0d mismatches.",
                 results_checked, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
